>>> rtl/assert_macros.svh
// Assertion helpers shared by the RTL files.
// Each macro takes a label, a clock, an active-low reset and the checked terms.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every rising clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
        else $error(msg);

// Antecedent implies consequent in the same cycle.
`define ASSERT_IMPLY(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Antecedent implies consequent in the next cycle.
`define ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/uqpd_pkg.sv
// ----------------------------------------------------------------------------
// uqpd_pkg
// Shared types, character codes and result codes of the URI query decoder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package uqpd_pkg;

    // Result kinds
    localparam logic [1:0] KIND_DATA     = 2'd0;
    localparam logic [1:0] KIND_PAIR_END = 2'd1;
    localparam logic [1:0] KIND_DONE     = 2'd2;

    // Part tags, also used as the parse phase
    localparam logic [1:0] PART_PATH  = 2'd0;
    localparam logic [1:0] PART_KEY   = 2'd1;
    localparam logic [1:0] PART_VALUE = 2'd2;

    // Done status
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_BAD_ENC  = 2'd1;
    localparam logic [1:0] ST_BAD_PATH = 2'd2;

    // Escape progress
    localparam logic [1:0] ESC_NONE   = 2'd0;
    localparam logic [1:0] ESC_FIRST  = 2'd1;
    localparam logic [1:0] ESC_SECOND = 2'd2;

    // Characters
    localparam logic [7:0] CH_QUESTION = 8'h3F;
    localparam logic [7:0] CH_AMP      = 8'h26;
    localparam logic [7:0] CH_SEMI     = 8'h3B;
    localparam logic [7:0] CH_EQUAL    = 8'h3D;
    localparam logic [7:0] CH_PERCENT  = 8'h25;
    localparam logic [7:0] CH_PLUS     = 8'h2B;
    localparam logic [7:0] CH_SPACE    = 8'h20;
    localparam logic [7:0] CH_SLASH    = 8'h2F;
    localparam logic [7:0] CH_DOT      = 8'h2E;

    // Results per input item, result queue depth
    localparam int MAX_RESULTS = 3;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 2);
    localparam int NRES_W      = $clog2(MAX_RESULTS + 1);

    typedef struct packed {
        logic [1:0] kind;
        logic [1:0] part;
        logic [7:0] data;
        logic [1:0] status;
        logic       last;
    } result_t;

    // Results produced by one item, packed from slot 0 upward
    typedef struct packed {
        logic [NRES_W-1:0]             count;
        result_t [MAX_RESULTS-1:0]     res;
    } result_group_t;

    typedef struct packed {
        logic [1:0] phase;
        logic [1:0] esc;
        logic [3:0] high_nibble;
        logic       path_seen;
        logic       path_bad;
        logic       prev_dot;
        logic       pair_nonempty;
        logic       enc_err;
    } parse_state_t;

    // Bit 4 set means not a hex digit
    function automatic logic [4:0] hex_value(input logic [7:0] c);
        logic [4:0] v;
        v = 5'h10;
        if (c >= 8'h30 && c <= 8'h39) v = {1'b0, 4'(c - 8'h30)};
        else if (c >= 8'h61 && c <= 8'h66) v = {1'b0, 4'(c - 8'h57)};
        else if (c >= 8'h41 && c <= 8'h46) v = {1'b0, 4'(c - 8'h37)};
        return v;
    endfunction

endpackage

`default_nettype wire

>>> rtl/uqpd_core.sv
// ----------------------------------------------------------------------------
// uqpd_core
// Parse state register and the per-byte decode step that yields up to three
// results for the byte held in the input register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module uqpd_core (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  advance,
    input  wire logic [7:0]            raw_byte,
    input  wire logic                  is_last,
    output uqpd_pkg::result_group_t    group
);

    uqpd_pkg::parse_state_t state_reg;
    uqpd_pkg::parse_state_t state_next;

    always_comb begin
        uqpd_pkg::parse_state_t ns;
        logic [4:0] h;
        logic       emit_data;
        logic [7:0] d;
        logic       pe_sep;
        logic       pe_end;
        logic [1:0] st;
        uqpd_pkg::result_t r;
        logic [uqpd_pkg::NRES_W-1:0] idx;

        ns        = state_reg;
        h         = uqpd_pkg::hex_value(raw_byte);
        emit_data = 1'b0;
        d         = raw_byte;
        pe_sep    = 1'b0;
        pe_end    = 1'b0;
        st        = uqpd_pkg::ST_OK;
        group     = '0;
        idx       = '0;
        r         = '0;

        if (!state_reg.enc_err) begin
            if (state_reg.esc != uqpd_pkg::ESC_NONE) begin
                if (h[4]) begin
                    ns.enc_err = 1'b1;
                end else if (state_reg.esc == uqpd_pkg::ESC_FIRST) begin
                    ns.high_nibble = h[3:0];
                    ns.esc         = uqpd_pkg::ESC_SECOND;
                end else begin
                    ns.esc    = uqpd_pkg::ESC_NONE;
                    emit_data = 1'b1;
                    d         = {state_reg.high_nibble, h[3:0]};
                end
            end else if (raw_byte == uqpd_pkg::CH_PERCENT) begin
                ns.esc = uqpd_pkg::ESC_FIRST;
                if (state_reg.phase != uqpd_pkg::PART_PATH) ns.pair_nonempty = 1'b1;
            end else if (state_reg.phase == uqpd_pkg::PART_PATH &&
                         raw_byte == uqpd_pkg::CH_QUESTION) begin
                ns.phase         = uqpd_pkg::PART_KEY;
                ns.pair_nonempty = 1'b0;
            end else if (state_reg.phase != uqpd_pkg::PART_PATH &&
                         (raw_byte == uqpd_pkg::CH_AMP || raw_byte == uqpd_pkg::CH_SEMI)) begin
                pe_sep           = state_reg.pair_nonempty;
                ns.phase         = uqpd_pkg::PART_KEY;
                ns.pair_nonempty = 1'b0;
            end else if (state_reg.phase == uqpd_pkg::PART_KEY &&
                         raw_byte == uqpd_pkg::CH_EQUAL) begin
                ns.phase         = uqpd_pkg::PART_VALUE;
                ns.pair_nonempty = 1'b1;
            end else begin
                emit_data = 1'b1;
                d = (raw_byte == uqpd_pkg::CH_PLUS) ? uqpd_pkg::CH_SPACE : raw_byte;
            end

            // path checks: must start with '/', no ".." anywhere
            if (emit_data) begin
                if (state_reg.phase == uqpd_pkg::PART_PATH) begin
                    if (!state_reg.path_seen && d != uqpd_pkg::CH_SLASH) ns.path_bad = 1'b1;
                    if (d == uqpd_pkg::CH_DOT && state_reg.prev_dot) ns.path_bad = 1'b1;
                    ns.prev_dot  = (d == uqpd_pkg::CH_DOT);
                    ns.path_seen = 1'b1;
                end else begin
                    ns.pair_nonempty = 1'b1;
                end
            end

            if (is_last && !ns.enc_err) begin
                if (ns.esc != uqpd_pkg::ESC_NONE) ns.enc_err = 1'b1;
                else if (ns.phase != uqpd_pkg::PART_PATH && ns.pair_nonempty) pe_end = 1'b1;
            end
        end

        if (ns.enc_err) st = uqpd_pkg::ST_BAD_ENC;
        else if (!ns.path_seen || ns.path_bad) st = uqpd_pkg::ST_BAD_PATH;

        // pack results in order
        if (emit_data) begin
            r      = '0;
            r.kind = uqpd_pkg::KIND_DATA;
            r.part = state_reg.phase;
            r.data = d;
            group.res[idx[1:0]] = r;
            idx = idx + 1'b1;
        end
        if (pe_sep) begin
            r      = '0;
            r.kind = uqpd_pkg::KIND_PAIR_END;
            group.res[idx[1:0]] = r;
            idx = idx + 1'b1;
        end
        if (pe_end) begin
            r      = '0;
            r.kind = uqpd_pkg::KIND_PAIR_END;
            group.res[idx[1:0]] = r;
            idx = idx + 1'b1;
        end
        if (is_last) begin
            r        = '0;
            r.kind   = uqpd_pkg::KIND_DONE;
            r.status = st;
            group.res[idx[1:0]] = r;
            idx = idx + 1'b1;
            ns = '0;
        end
        if (idx != '0) group.res[2'(idx - 1'b1)].last = 1'b1;
        group.count = idx;
        state_next  = ns;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= '0;
        end else if (advance) begin
            state_reg <= state_next;
        end
    end

    `include "assert_macros.svh"

    `ASSERT_ALWAYS(a_esc_code, aclk, aresetn, state_reg.esc != 2'd3, "escape stage out of range")
    `ASSERT_IMPLY(a_done_clears, aclk, aresetn, advance && is_last, state_next == '0, "state not cleared at end of URI")
    `ASSERT_IMPLY(a_path_phase_no_pair, aclk, aresetn, state_reg.phase == uqpd_pkg::PART_PATH, !state_reg.pair_nonempty, "pair flag set inside path")

endmodule

`default_nettype wire

>>> rtl/uqpd_resq.sv
// ----------------------------------------------------------------------------
// uqpd_resq
// Result queue: takes up to three results per cycle when it has room, hands
// out one per transfer on the result channel.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module uqpd_resq (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       push,
    input  wire uqpd_pkg::result_group_t    group,
    output logic                            room,
    output logic                            m_valid,
    input  wire logic                       m_ready,
    output uqpd_pkg::result_t               head
);

    uqpd_pkg::result_t                  mem_reg [uqpd_pkg::QUEUE_DEPTH];
    logic [uqpd_pkg::QPTR_W-1:0]        wr_ptr_reg;
    logic [uqpd_pkg::QPTR_W-1:0]        rd_ptr_reg;
    logic [uqpd_pkg::QCNT_W-1:0]        count_reg;
    logic [uqpd_pkg::QCNT_W-1:0]        count_next;
    logic [uqpd_pkg::QCNT_W-1:0]        space;
    logic [uqpd_pkg::QCNT_W-1:0]        n_push;
    logic                               pop;

    assign m_valid = (count_reg != '0);
    assign pop     = m_valid && m_ready;
    assign head    = mem_reg[rd_ptr_reg];
    assign space   = uqpd_pkg::QCNT_W'(uqpd_pkg::QUEUE_DEPTH) - count_reg
                     + uqpd_pkg::QCNT_W'(pop);
    assign room    = (uqpd_pkg::QCNT_W'(group.count) <= space);
    assign n_push  = push ? uqpd_pkg::QCNT_W'(group.count) : '0;
    assign count_next = count_reg + n_push - uqpd_pkg::QCNT_W'(pop);

    always_ff @(posedge aclk) begin
        for (int i = 0; i < uqpd_pkg::MAX_RESULTS; i++) begin
            if (push && (uqpd_pkg::NRES_W'(i) < group.count)) begin
                mem_reg[wr_ptr_reg + uqpd_pkg::QPTR_W'(i)] <= group.res[i];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) wr_ptr_reg <= wr_ptr_reg + uqpd_pkg::QPTR_W'(group.count);
            if (pop)  rd_ptr_reg <= rd_ptr_reg + 1'b1;
            count_reg <= count_next;
        end
    end

    `include "assert_macros.svh"

    `ASSERT_ALWAYS(a_no_overflow, aclk, aresetn, count_reg <= uqpd_pkg::QCNT_W'(uqpd_pkg::QUEUE_DEPTH), "result queue overflow")
    `ASSERT_IMPLY(a_push_fits, aclk, aresetn, push, room, "push without room")
    `ASSERT_NEXT(a_count_track, aclk, aresetn, !push && !pop, $stable(count_reg), "count moved without push or pop")

endmodule

`default_nettype wire

>>> rtl/uri_query_percent_decoder_unit.sv
// ----------------------------------------------------------------------------
// uri_query_percent_decoder_unit
// Percent decoder for a request URI with path/query split and key/value
// pair framing; one raw byte in, zero to three tagged results out.
//
//   Channel  Dir  Handshake          Payload
//   s_       in   s_valid/s_ready    s_raw_byte, s_is_last
//   m_       out  m_valid/m_ready    m_kind, m_part, m_decoded_byte,
//                                    m_status, m_last_of_run
//
// One byte per cycle while each byte yields at most one result; the result
// queue drains one result per cycle while m_ready is high, so bytes with
// two or three results (pair ends, done) hold up later bytes. Reset
// (aresetn low, synchronous) empties the queue and returns the parser to
// the start of a URI. A stall on m_ready backs up into s_ready only once
// the queue lacks room for the next byte.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module uri_query_percent_decoder_unit (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire logic [7:0] s_raw_byte,
    input  wire logic       s_is_last,
    output logic            m_valid,
    input  wire logic       m_ready,
    output logic [1:0]      m_kind,
    output logic [1:0]      m_part,
    output logic [7:0]      m_decoded_byte,
    output logic [1:0]      m_status,
    output logic            m_last_of_run
);

    logic                     in_valid_reg;
    logic [7:0]               in_byte_reg;
    logic                     in_last_reg;
    logic                     advance;
    logic                     room;
    uqpd_pkg::result_group_t  group;
    uqpd_pkg::result_t        head;

    assign advance = in_valid_reg && room;
    assign s_ready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_byte_reg <= s_raw_byte;
            in_last_reg <= s_is_last;
        end
    end

    uqpd_core u_core (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .advance  (advance),
        .raw_byte (in_byte_reg),
        .is_last  (in_last_reg),
        .group    (group)
    );

    uqpd_resq u_resq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (advance),
        .group   (group),
        .room    (room),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .head    (head)
    );

    assign m_kind         = head.kind;
    assign m_part         = head.part;
    assign m_decoded_byte = head.data;
    assign m_status       = head.status;
    assign m_last_of_run  = head.last;

    `include "assert_macros.svh"

    `ASSERT_IMPLY(a_done_ends_run, aclk, aresetn, m_valid && m_kind == uqpd_pkg::KIND_DONE, m_last_of_run, "done result not last of run")
    `ASSERT_IMPLY(a_held_blocks, aclk, aresetn, in_valid_reg && !room, !s_ready, "input taken while held byte waits")

endmodule

`default_nettype wire
